/* src/tmfe_pkg.sv */
// Shared constants, types and tables for the transition matrix block.
package tmfe_pkg;

  localparam int MAX_STATES = 4;
  localparam int COEF_DEPTH = MAX_STATES * MAX_STATES * MAX_STATES;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int IDX_W      = $clog2(MAX_STATES);
  localparam int NST_W      = 3;
  localparam int LEN_W      = 31;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int EXP_TERMS  = 12;
  localparam int TERM_W     = 4;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 36;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int EACC_W     = 44;

  localparam logic [31:0] ONE_Q30   = 32'd1073741824;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [29:0] ARG_LIMIT = 30'd536870912;

  localparam logic [NST_W-1:0]  NST_RESET = NST_W'(4);
  localparam logic [LEN_W-1:0]  MIN_LEN_RESET = LEN_W'(17);

  // input operation codes
  localparam logic [1:0] OP_LOAD_COEF  = 2'd0;
  localparam logic [1:0] OP_LOAD_EIGEN = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd1;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_EQ    = 15'b000000000000010,
    ST_ET    = 15'b000000000000100,
    ST_EN    = 15'b000000000001000,
    ST_ER    = 15'b000000000010000,
    ST_EH    = 15'b000000000100000,
    ST_HM    = 15'b000000001000000,
    ST_HD    = 15'b000000010000000,
    ST_HC    = 15'b000000100000000,
    ST_EF    = 15'b000001000000000,
    ST_RD    = 15'b000010000000000,
    ST_USE   = 15'b000100000000000,
    ST_ADD   = 15'b001000000000000,
    ST_EMIT  = 15'b010000000000000,
    ST_SHORT = 15'b100000000000000
  } state_t;

  // ceil(2^36 / k): exact quotient for dividends below 2^32
  function automatic logic [MUL_B_W-1:0] recip(input logic [TERM_W-1:0] k);
    logic [MUL_B_W-1:0] v;
    case (k)
      4'd2:    v = 36'd34359738368;
      4'd3:    v = 36'd22906492246;
      4'd4:    v = 36'd17179869184;
      4'd5:    v = 36'd13743895348;
      4'd6:    v = 36'd11453246123;
      4'd7:    v = 36'd9817068106;
      4'd8:    v = 36'd8589934592;
      4'd9:    v = 36'd7635497416;
      4'd10:   v = 36'd6871947674;
      4'd11:   v = 36'd6247225158;
      4'd12:   v = 36'd5726623062;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/transition_matrix_from_eigensystem.sv */
// Top level: transition probability matrix from an eigen-decomposition.
//
// Load beats (op 0/1) are taken while idle and leave busy low. A compute
// beat raises busy until the last entry is out. With N states it forms N-1
// exponentials on one shared 32x36 multiplier (Horner steps need a multiply
// and a reciprocal multiply each), skipping the Horner steps when the
// exponential saturates high. Then each of the N*N entries is formed through
// the registered-read coefficient RAM and the same multiplier. A short
// branch emits one entry per cycle. Each entry is shown for one cycle with
// result_valid; the receiver cannot stall.
module transition_matrix_from_eigensystem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic [5:0]                        load_index,
  input  logic signed [31:0]                load_value,
  input  logic [30:0]                       branch_length,
  input  logic                              cumulative,
  input  logic                              cfg_write,
  input  logic [tmfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmfe_pkg::CFG_W-1:0]        cfg_data,
  output logic                              result_valid,
  output logic [1:0]                        row,
  output logic [1:0]                        column,
  output logic signed [31:0]                probability,
  output logic                              last
);

  import tmfe_pkg::*;

  state_t state;

  // configuration
  logic [NST_W-1:0] num_states;
  logic [LEN_W-1:0] min_length;

  // item context
  logic [NST_W-1:0] nst;
  logic [LEN_W-1:0] len;
  logic             cum;

  logic signed [31:0] eigen [MAX_STATES];
  logic [31:0]        expo  [MAX_STATES];

  // exponential datapath
  logic [IDX_W-1:0]  ek;
  logic              eneg;
  logic signed [7:0] eshift;
  logic [29:0]       ef30;
  logic [29:0]       er;
  logic [31:0]       hacc;
  logic [TERM_W-1:0] hk;

  // entry datapath
  logic [COEF_AW-1:0]        caddr;
  logic [IDX_W-1:0]          ci, cj, kk;
  logic                      csign;
  logic signed [EACC_W-1:0]  eacc;
  logic signed [31:0]        rsum;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  logic [31:0]        rdata;
  logic signed [31:0] cval;
  logic [31:0]        cmag;

  logic [NST_W-1:0] nst_clamped;
  logic [IDX_W-1:0] nm1;
  logic             accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign nm1    = IDX_W'(nst - NST_W'(1));
  assign cval   = signed'(rdata);
  assign cmag   = cval[31] ? 32'(-cval) : rdata;

  always_comb begin
    if (num_states < NST_W'(2)) begin
      nst_clamped = NST_W'(2);
    end else if (num_states > NST_W'(MAX_STATES)) begin
      nst_clamped = NST_W'(MAX_STATES);
    end else begin
      nst_clamped = num_states;
    end
  end

  tmfe_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk   (clk),
    .we    (accept && op == OP_LOAD_COEF),
    .waddr (load_index[COEF_AW-1:0]),
    .wdata (load_value),
    .raddr (caddr),
    .rdata (rdata)
  );

  // exponential argument: |t*L| in Q.24, clamped to 32.0
  logic [29:0] qarg;
  always_comb begin
    if (prod[62:24] > 39'(ARG_LIMIT)) begin
      qarg = ARG_LIMIT;
    end else begin
      qarg = prod[53:24];
    end
  end

  // operand select for the shared multiplier
  logic [31:0] emag;
  always_comb begin
    emag  = eigen[ek][31] ? 32'(-eigen[ek]) : eigen[ek];
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_EQ: begin
        mul_a = MUL_A_W'(len);
        mul_b = MUL_B_W'(emag);
      end
      ST_ET: begin
        mul_a = MUL_A_W'(qarg);
        mul_b = MUL_B_W'(LOG2E_Q30);
      end
      ST_ER: begin
        mul_a = MUL_A_W'(ef30);
        mul_b = MUL_B_W'(LN2_Q30);
      end
      ST_HM: begin
        mul_a = hacc;
        mul_b = MUL_B_W'(er);
      end
      ST_HD: begin
        mul_a = prod[61:30];
        mul_b = recip(hk);
      end
      ST_USE: begin
        mul_a = cmag;
        mul_b = MUL_B_W'(expo[kk]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // split y = n + f, folding in the sign of the eigenvalue
  logic [6:0]        nint;
  logic [53:0]       frac;
  logic signed [7:0] nsplit;
  logic [53:0]       fadj;
  always_comb begin
    nint = prod[60:54];
    frac = prod[53:0];
    if (eneg && frac != '0) begin
      nsplit = -$signed({1'b0, nint}) - 8'sd1;
      fadj   = 54'(55'h40000000000000 - {1'b0, frac});
    end else if (eneg) begin
      nsplit = -$signed({1'b0, nint});
      fadj   = frac;
    end else begin
      nsplit = $signed({1'b0, nint});
      fadj   = frac;
    end
  end

  // scale e^r by 2^n
  logic [31:0] escaled;
  logic [7:0]  rsh;
  always_comb begin
    rsh = 8'(-eshift);
    if (eshift == 8'sd1) begin
      escaled = hacc[31] ? 32'hFFFFFFFF : {hacc[30:0], 1'b0};
    end else if (eshift == 8'sd0) begin
      escaled = hacc;
    end else if (rsh >= 8'd32) begin
      escaled = '0;
    end else begin
      escaled = hacc >> rsh[4:0];
    end
  end

  // entry saturation and running row sum
  logic signed [31:0] psat;
  logic signed [32:0] rsum_wide;
  logic signed [31:0] rsum_sat;
  logic signed [31:0] pout;
  logic               elast;
  always_comb begin
    if (eacc > EACC_W'(64'sh7FFFFFFF)) begin
      psat = 32'sh7FFFFFFF;
    end else if (eacc < -EACC_W'(64'sh80000000)) begin
      psat = 32'sh80000000;
    end else begin
      psat = eacc[31:0];
    end
    rsum_wide = {rsum[31], rsum} + {psat[31], psat};
    if (rsum_wide > 33'sh07FFFFFFF) begin
      rsum_sat = 32'sh7FFFFFFF;
    end else if (rsum_wide < -33'sh080000000) begin
      rsum_sat = 32'sh80000000;
    end else begin
      rsum_sat = rsum_wide[31:0];
    end
    pout  = cum ? rsum_sat : psat;
    elast = (ci == nm1) && (cj == nm1);
  end

  logic signed [EACC_W-1:0] cterm;
  assign cterm = $signed({4'b0, prod[63:24]});

  // sequencer
  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state      <= ST_IDLE;
      num_states <= NST_RESET;
      min_length <= MIN_LEN_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_NUM_STATES: num_states <= cfg_data[NST_W-1:0];
          CFG_MIN_LENGTH: min_length <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD_EIGEN: begin
                if (load_index < 6'(MAX_STATES)) begin
                  eigen[load_index[IDX_W-1:0]] <= load_value;
                end
              end
              OP_COMPUTE: begin
                nst   <= nst_clamped;
                len   <= branch_length;
                cum   <= cumulative;
                ci    <= '0;
                cj    <= '0;
                kk    <= '0;
                caddr <= '0;
                rsum  <= '0;
                ek    <= IDX_W'(1);
                state <= (branch_length < min_length) ? ST_SHORT : ST_EQ;
              end
              default: ;
            endcase
          end
        end
        ST_EQ: begin
          eneg  <= eigen[ek][31];
          state <= ST_ET;
        end
        ST_ET: begin
          state <= ST_EN;
        end
        ST_EN: begin
          eshift <= nsplit;
          ef30   <= fadj[53:24];
          if (!eneg && nint >= 7'd2) begin
            // saturate and move on
            expo[ek] <= 32'hFFFFFFFF;
            ek       <= ek + IDX_W'(1);
            state    <= (ek == nm1) ? ST_RD : ST_EQ;
          end else begin
            state <= ST_ER;
          end
        end
        ST_ER: begin
          state <= ST_EH;
        end
        ST_EH: begin
          er    <= prod[59:30];
          hacc  <= ONE_Q30;
          hk    <= TERM_W'(EXP_TERMS);
          state <= ST_HM;
        end
        ST_HM: begin
          state <= ST_HD;
        end
        ST_HD: begin
          if (hk == TERM_W'(1)) begin
            hacc  <= ONE_Q30 + prod[61:30];
            state <= ST_EF;
          end else begin
            state <= ST_HC;
          end
        end
        ST_HC: begin
          hacc  <= ONE_Q30 + prod[67:36];
          hk    <= hk - TERM_W'(1);
          state <= ST_HM;
        end
        ST_EF: begin
          expo[ek] <= escaled;
          ek       <= ek + IDX_W'(1);
          state    <= (ek == nm1) ? ST_RD : ST_EQ;
        end
        ST_RD: begin
          state <= ST_USE;
        end
        ST_USE: begin
          caddr <= caddr + COEF_AW'(1);
          if (kk == '0) begin
            eacc  <= $signed({{(EACC_W-32){cval[31]}}, cval}) <<< 6;
            kk    <= IDX_W'(1);
            state <= ST_RD;
          end else begin
            csign <= cval[31];
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          eacc <= csign ? eacc - cterm : eacc + cterm;
          if (kk == nm1) begin
            state <= ST_EMIT;
          end else begin
            kk    <= kk + IDX_W'(1);
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          row          <= ci;
          column       <= cj;
          probability  <= pout;
          last         <= elast;
          kk           <= '0;
          if (cj == nm1) begin
            rsum <= '0;
            cj   <= '0;
            ci   <= ci + IDX_W'(1);
          end else begin
            rsum <= rsum_sat;
            cj   <= cj + IDX_W'(1);
          end
          state <= elast ? ST_IDLE : ST_RD;
        end
        ST_SHORT: begin
          result_valid <= 1'b1;
          row          <= ci;
          column       <= cj;
          probability  <= ((cum && ci <= cj) || ci == cj) ? signed'(ONE_Q30) : '0;
          last         <= elast;
          if (cj == nm1) begin
            cj <= '0;
            ci <= ci + IDX_W'(1);
          end else begin
            cj <= cj + IDX_W'(1);
          end
          if (elast) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // every entry comes out of a busy sequence
  a_valid_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a compute in flight");

  // the final entry ends the sequence
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("busy after final entry");

  // entries before the final one keep the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("block idle in the middle of a matrix");
`endif

endmodule

/* src/tmfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tmfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
